>>> rtl/core/pdbs_pkg.sv
// Package for the pair difference search block: sizes, the sequencer state
// type and the request structure that goes to the element memory.
// No dependencies.
`default_nettype none

package pdbs_pkg;

  // Element store depth and derived widths.
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int SUM_W    = DATA_W + 1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ELEM_RD,
    ST_ELEM,
    ST_PROBE,
    ST_CMP,
    ST_HIT,
    ST_NEXT,
    ST_DONE
  } state_t;

  // Access request from the sequencer to the element memory.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/core/pdbs_store.sv
// Element memory of the pair difference search: one write and one read port,
// read data registered.
// Depends on pdbs_pkg.
`default_nettype none

module pdbs_store (
  input  wire logic                      clk,
  input  wire pdbs_pkg::mem_req_t        req,
  output logic [pdbs_pkg::DATA_W-1:0]    rd_data
);
  import pdbs_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pdbs_search.sv
// Sequencer of the pair difference search: loads the list into the element
// memory, runs one binary search per stored element and stages the results.
// Depends on pdbs_pkg; drives pdbs_store through a mem_req_t request.
`default_nettype none

module pdbs_search (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [pdbs_pkg::DATA_W-1:0]   diff,
  // Input stream.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pdbs_pkg::DATA_W-1:0]   in_value,
  input  wire logic                          in_last,
  // Element memory.
  output pdbs_pkg::mem_req_t                 req,
  input  wire logic [pdbs_pkg::DATA_W-1:0]   rd_data,
  // Result stream.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pdbs_pkg::DATA_W-1:0]        out_first,
  output logic [pdbs_pkg::SUM_W-1:0]         out_second,
  output logic                               out_pair,
  output logic                               out_end,
  output logic                               out_trunc
);
  import pdbs_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic              overflow, overflow_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  hi_p1, hi_p1_next;
  logic [ADDR_W-1:0] mid, mid_next;
  logic [DATA_W-1:0] elem, elem_next;
  logic [SUM_W-1:0]  want, want_next;

  // Result held back until it is known whether it is the last of the run.
  logic              held_valid, held_valid_next;
  logic [DATA_W-1:0] held_first, held_first_next;
  logic [SUM_W-1:0]  held_second, held_second_next;

  logic              out_valid_next, out_pair_next, out_end_next, out_trunc_next;
  logic [DATA_W-1:0] out_first_next;
  logic [SUM_W-1:0]  out_second_next;

  logic              out_free;
  logic [CNT_W:0]    mid_sum;
  logic [SUM_W-1:0]  probe_val;
  logic              accept;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_LOAD);
  assign accept    = in_valid && in_ready;
  assign mid_sum   = {1'b0, lo} + {1'b0, hi_p1} - (CNT_W + 1)'(1);
  assign probe_val = {rd_data[DATA_W-1], rd_data};

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      overflow   <= 1'b0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      overflow   <= overflow_next;
      held_valid <= held_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    lo          <= lo_next;
    hi_p1       <= hi_p1_next;
    mid         <= mid_next;
    elem        <= elem_next;
    want        <= want_next;
    held_first  <= held_first_next;
    held_second <= held_second_next;
    out_first   <= out_first_next;
    out_second  <= out_second_next;
    out_pair    <= out_pair_next;
    out_end     <= out_end_next;
    out_trunc   <= out_trunc_next;
  end

  // Next state, memory requests and result staging.
  always_comb begin
    state_next       = state;
    count_next       = count;
    overflow_next    = overflow;
    idx_next         = idx;
    lo_next          = lo;
    hi_p1_next       = hi_p1;
    mid_next         = mid;
    elem_next        = elem;
    want_next        = want;
    held_valid_next  = held_valid;
    held_first_next  = held_first;
    held_second_next = held_second;
    out_valid_next   = out_valid && !out_ready;
    out_first_next   = out_first;
    out_second_next  = out_second;
    out_pair_next    = out_pair;
    out_end_next     = out_end;
    out_trunc_next   = out_trunc;
    req              = '0;
    req.wr_addr      = count[ADDR_W-1:0];
    req.wr_data      = in_value;
    req.rd_addr      = idx;

    case (state)
      // Store each element while there is room; a last mark starts the scan.
      ST_LOAD: begin
        idx_next = '0;
        if (accept) begin
          if (count < CNT_W'(CAPACITY)) begin
            req.wr_en  = 1'b1;
            count_next = count + CNT_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (in_last) begin
            state_next = ST_ELEM_RD;
          end
        end
      end
      // Fetch the element that begins a candidate pair.
      ST_ELEM_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = idx;
        state_next  = ST_ELEM;
      end
      // Form the exact 33-bit target and open the search window.
      ST_ELEM: begin
        elem_next  = rd_data;
        want_next  = probe_val + {diff[DATA_W-1], diff};
        lo_next    = '0;
        hi_p1_next = count;
        state_next = ST_PROBE;
      end
      // Read the midpoint while the window is not empty.
      ST_PROBE: begin
        if (lo < hi_p1) begin
          mid_next    = mid_sum[ADDR_W:1];
          req.rd_en   = 1'b1;
          req.rd_addr = mid_sum[ADDR_W:1];
          state_next  = ST_CMP;
        end else begin
          state_next = ST_NEXT;
        end
      end
      // Compare the probed element and narrow the window.
      ST_CMP: begin
        if (probe_val == want) begin
          state_next = ST_HIT;
        end else if ($signed(probe_val) > $signed(want)) begin
          hi_p1_next = {1'b0, mid};
          state_next = ST_PROBE;
        end else begin
          lo_next    = {1'b0, mid} + CNT_W'(1);
          state_next = ST_PROBE;
        end
      end
      // Release the previous hit (not last) and hold the new one.
      ST_HIT: begin
        if (out_free) begin
          if (held_valid) begin
            out_valid_next  = 1'b1;
            out_first_next  = held_first;
            out_second_next = held_second;
            out_pair_next   = 1'b1;
            out_end_next    = 1'b0;
            out_trunc_next  = overflow;
          end
          held_valid_next  = 1'b1;
          held_first_next  = elem;
          held_second_next = want;
          state_next       = ST_NEXT;
        end
      end
      // Move to the next stored element or finish.
      ST_NEXT: begin
        if ({1'b0, idx} + CNT_W'(1) == count) begin
          state_next = ST_DONE;
        end else begin
          idx_next   = idx + ADDR_W'(1);
          state_next = ST_ELEM_RD;
        end
      end
      // Close the run with the held hit, or with an empty result.
      ST_DONE: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_first_next  = held_valid ? held_first : '0;
          out_second_next = held_valid ? held_second : '0;
          out_pair_next   = held_valid;
          out_end_next    = 1'b1;
          out_trunc_next  = overflow;
          held_valid_next = 1'b0;
          count_next      = '0;
          overflow_next   = 1'b0;
          state_next      = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  // The search window stays inside the loaded list.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (lo <= hi_p1 + CNT_W'(1)) && (hi_p1 <= count))
    else $error("search window out of range");

  // No result is held back while a list is being loaded.
  a_held_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !held_valid)
    else $error("held result during load");

  // Closing a run clears the list and emits a final result.
  a_close: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (count == '0) && !overflow && out_valid && out_end)
    else $error("run not closed properly");

endmodule

`default_nettype wire

>>> rtl/core/pair_difference_binary_search.sv
// Pair difference search over a sorted list, top level.
// Loading accepts one element per cycle. After the last element each stored
// element is read, its target formed and a binary search run (at most 7 probes for
// 64 entries, one memory read each); the run then closes with a final result,
// and a stalled result stream holds the search while it waits.
// Synchronous active-high reset clears the list, flags, output valid and the
// difference register; the element memory itself is not cleared.
// Depends on pdbs_pkg, pdbs_store and pdbs_search.
`default_nettype none

module pair_difference_binary_search (
  input  wire logic         clk,
  input  wire logic         rst,
  // Configuration: target_difference.
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata,
  // Input stream.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // [31:0] element_value
  input  wire logic         s_tlast,   // is_last
  // Result stream.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [71:0]       m_tdata,   // [31:0] first_value, [64:32] second_value, zero fill
  output logic [1:0]        m_tuser,   // [0] pair_valid, [1] truncated
  output logic              m_tlast    // end_of_run
);
  import pdbs_pkg::*;

  logic [DATA_W-1:0] target_difference;
  mem_req_t          req;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] out_first;
  logic [SUM_W-1:0]  out_second;
  logic              out_pair;
  logic              out_trunc;

  // Difference register.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_difference <= '0;
    end else if (cfg_we) begin
      target_difference <= cfg_wdata;
    end
  end

  pdbs_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  pdbs_search u_search (
    .clk        (clk),
    .rst        (rst),
    .diff       (target_difference),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata),
    .in_last    (s_tlast),
    .req        (req),
    .rd_data    (rd_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_first  (out_first),
    .out_second (out_second),
    .out_pair   (out_pair),
    .out_end    (m_tlast),
    .out_trunc  (out_trunc)
  );

  // Pack the result fields onto the stream.
  assign m_tdata = {7'b0, out_second, out_first};
  assign m_tuser = {out_trunc, out_pair};

endmodule

`default_nettype wire
